// ----- design/drr_pkg.sv -----
// Shared types and constants of the deficit round robin scheduler.
`default_nettype none
package drr_pkg;

   localparam int SESSIONS_DEF    = 16;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int LEN_W           = 14;
   localparam int WT_W            = 4;
   localparam int SID_W           = 4;
   localparam int PKT_W           = LEN_W + WT_W;
   localparam int DEF_W           = 32;
   localparam int QUANT_W         = 16;
   localparam int CREDIT_W        = QUANT_W + WT_W;
   localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd1500;

   localparam logic [1:0] ST_QUEUED  = 2'd0;
   localparam logic [1:0] ST_GRANTED = 2'd1;
   localparam logic [1:0] ST_DROPPED = 2'd2;
   localparam logic [1:0] ST_IDLE    = 2'd3;

   typedef enum logic [2:0] {
      RSP_GRANT_REQ,
      RSP_QUEUED,
      RSP_DROP,
      RSP_IDLE,
      RSP_GRANT_SEL
   } rsp_kind_type;

   typedef struct packed {
      logic         capture;
      logic         sel_req;
      logic         sel_cur;
      logic         sel_next;
      logic         pkt_rd;
      logic         mul;
      logic         clr_credit;
      logic         wr_arrive;
      logic         wr_keep;
      logic         wr_visit;
      logic         rsp_en;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic func;
      logic link_busy;
      logic sess_oor;
      logic full;
      logic cnt_zero;
      logic cur_fits;
      logic visit_fits;
      logic at_cur;
      logic credit_any;
   } stat_type;

endpackage
`default_nettype wire

// ----- design/drr_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module drr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- design/drr_ctrl.sv -----
// Controller state machine of the deficit round robin scheduler.
`default_nettype none
module drr_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire drr_pkg::stat_type  stat,
   output      drr_pkg::cmd_type   cmd
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_DISPATCH = 9'b000000010,
      S_ARR_RD   = 9'b000000100,
      S_FIN_RD   = 9'b000001000,
      S_FIN_CHK  = 9'b000010000,
      S_SC_RD    = 9'b000100000,
      S_SC_MUL   = 9'b001000000,
      S_SC_VIS   = 9'b010000000,
      S_SPARE    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_kind = drr_pkg::RSP_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!stat.func) begin
               if (!stat.link_busy) begin
                  cmd.rsp_en   = 1'b1;
                  cmd.rsp_kind = drr_pkg::RSP_GRANT_REQ;
                  state_in     = S_IDLE;
               end else if (stat.sess_oor) begin
                  cmd.rsp_en   = 1'b1;
                  cmd.rsp_kind = drr_pkg::RSP_DROP;
                  state_in     = S_IDLE;
               end else begin
                  cmd.sel_req = 1'b1;
                  state_in    = S_ARR_RD;
               end
            end else begin
               cmd.sel_cur = 1'b1;
               state_in    = S_FIN_RD;
            end
         end
         S_ARR_RD: begin
            cmd.rsp_en = 1'b1;
            if (stat.full) begin
               cmd.rsp_kind = drr_pkg::RSP_DROP;
            end else begin
               cmd.wr_arrive = 1'b1;
               cmd.rsp_kind  = drr_pkg::RSP_QUEUED;
            end
            state_in = S_IDLE;
         end
         S_FIN_RD: begin
            cmd.pkt_rd = 1'b1;
            state_in   = S_FIN_CHK;
         end
         S_FIN_CHK: begin
            if (!stat.cnt_zero && stat.cur_fits) begin
               cmd.wr_keep  = 1'b1;
               cmd.rsp_en   = 1'b1;
               cmd.rsp_kind = drr_pkg::RSP_GRANT_SEL;
               state_in     = S_IDLE;
            end else begin
               cmd.wr_visit   = stat.cnt_zero;
               cmd.clr_credit = 1'b1;
               cmd.sel_next   = 1'b1;
               state_in       = S_SC_RD;
            end
         end
         S_SC_RD: begin
            cmd.pkt_rd = 1'b1;
            state_in   = S_SC_MUL;
         end
         S_SC_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SC_VIS;
         end
         S_SC_VIS: begin
            cmd.wr_visit = 1'b1;
            if (stat.visit_fits) begin
               cmd.rsp_en   = 1'b1;
               cmd.rsp_kind = drr_pkg::RSP_GRANT_SEL;
               state_in     = S_IDLE;
            end else if (stat.at_cur && !stat.credit_any) begin
               cmd.rsp_en   = 1'b1;
               cmd.rsp_kind = drr_pkg::RSP_IDLE;
               state_in     = S_IDLE;
            end else begin
               cmd.clr_credit = stat.at_cur;
               cmd.sel_next   = 1'b1;
               state_in       = S_SC_RD;
            end
         end
         S_SPARE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- design/drr_dp.sv -----
// Datapath of the deficit round robin scheduler: session table, packet store, credit.
`default_nettype none
module drr_dp #(
   parameter int SESSIONS    = drr_pkg::SESSIONS_DEF,
   parameter int QUEUE_DEPTH = drr_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire drr_pkg::cmd_type            cmd,
   output      drr_pkg::stat_type           stat,
   input  wire logic                        req_func,
   input  wire logic [drr_pkg::SID_W-1:0]   req_session,
   input  wire logic [drr_pkg::LEN_W-1:0]   req_packet_length,
   input  wire logic [drr_pkg::WT_W-1:0]    req_weight,
   input  wire logic                        csr_wr,
   input  wire logic [drr_pkg::QUANT_W-1:0] csr_quantum,
   output      logic                        rsp_strobe,
   output      logic [1:0]                  rsp_status,
   output      logic [drr_pkg::SID_W-1:0]   rsp_grant_session,
   output      logic [drr_pkg::LEN_W-1:0]   rsp_grant_length
);

   localparam int SW    = $clog2(SESSIONS);
   localparam int HW    = $clog2(QUEUE_DEPTH);
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int SWW   = drr_pkg::DEF_W + HW + CW;
   localparam int PD    = SESSIONS * QUEUE_DEPTH;
   localparam int AW    = $clog2(PD);
   localparam int DW    = drr_pkg::DEF_W;
   localparam int LW    = drr_pkg::LEN_W;

   logic                        req_func_ff;
   logic [drr_pkg::SID_W-1:0]   req_sess_ff;
   logic [LW-1:0]               req_len_ff;
   logic [drr_pkg::WT_W-1:0]    req_wt_ff;
   logic [drr_pkg::QUANT_W-1:0] quantum_ff;
   logic                        link_busy_ff, link_busy_in;
   logic [SW-1:0]               cur_ff, cur_in;
   logic [SW-1:0]               sel_ff, sel_in, sel_nxt;
   logic [SESSIONS-1:0]         valid_ff;
   logic                        rd_valid_ff;
   logic [drr_pkg::CREDIT_W-1:0] credit_ff;
   logic                        credit_any_ff;
   logic                        rsp_strobe_ff;
   logic [1:0]                  rsp_status_ff;
   logic [drr_pkg::SID_W-1:0]   rsp_sess_ff;
   logic [LW-1:0]               rsp_len_ff;

   logic [SWW-1:0]              sw_q, sw, sw_wdata;
   logic                        sw_rd, sw_wr;
   logic [DW-1:0]               def;
   logic [HW-1:0]               head, head_nxt;
   logic [CW-1:0]               cnt;
   logic [drr_pkg::PKT_W-1:0]   pkt_q, pkt_wdata;
   logic [LW-1:0]               plen;
   logic [drr_pkg::WT_W-1:0]    pwt;
   logic [HW:0]                 slot_sum;
   logic [HW-1:0]               slot;
   logic [AW-1:0]               base, pkt_raddr, pkt_waddr;
   logic [DW:0]                 sum, diff;
   logic [DW-1:0]               sum_sat, diff_sat;
   logic                        vfits;

   assign def  = sw[SWW-1 -: DW];
   assign head = sw[CW +: HW];
   assign cnt  = sw[CW-1:0];
   assign sw   = rd_valid_ff ? sw_q : '0;
   assign plen = pkt_q[LW-1:0];
   assign pwt  = pkt_q[drr_pkg::PKT_W-1 -: drr_pkg::WT_W];

   assign head_nxt = (head == HW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
   assign sel_nxt  = (sel_ff == SW'(SESSIONS - 1)) ? '0 : sel_ff + 1'b1;

   always_comb begin
      sel_in = sel_ff;
      if (cmd.sel_req) begin
         sel_in = SW'(req_sess_ff);
      end else if (cmd.sel_cur) begin
         sel_in = cur_ff;
      end else if (cmd.sel_next) begin
         sel_in = sel_nxt;
      end
   end
   assign sw_rd = cmd.sel_req | cmd.sel_cur | cmd.sel_next;

   assign base      = AW'(AW'(sel_ff) * AW'(QUEUE_DEPTH));
   assign pkt_raddr = base + AW'(head);
   assign slot_sum  = (HW + 1)'(head) + (HW + 1)'(cnt);
   assign slot      = (slot_sum >= (HW + 1)'(QUEUE_DEPTH)) ?
                      HW'(slot_sum - (HW + 1)'(QUEUE_DEPTH)) : HW'(slot_sum);
   assign pkt_waddr = base + AW'(slot);
   assign pkt_wdata = {req_wt_ff, req_len_ff};

   assign sum      = (DW + 1)'(def) + (DW + 1)'(credit_ff);
   assign diff     = sum - (DW + 1)'(plen);
   assign sum_sat  = sum[DW] ? '1 : sum[DW-1:0];
   assign diff_sat = diff[DW] ? '1 : diff[DW-1:0];
   assign vfits    = (cnt != '0) && ((DW + 1)'(plen) <= sum);

   always_comb begin
      sw_wr    = cmd.wr_arrive | cmd.wr_keep | cmd.wr_visit;
      sw_wdata = sw;
      if (cmd.wr_arrive) begin
         sw_wdata = {def, head, cnt + 1'b1};
      end else if (cmd.wr_keep) begin
         sw_wdata = {def - DW'(plen), head_nxt, cnt - 1'b1};
      end else if (cnt == '0) begin
         sw_wdata = {{DW{1'b0}}, head, cnt};
      end else if (vfits) begin
         sw_wdata = {diff_sat, head_nxt, cnt - 1'b1};
      end else begin
         sw_wdata = {sum_sat, head, cnt};
      end
   end

   drr_ram #(.WIDTH(SWW), .DEPTH(SESSIONS)) u_sess_ram (
      .clock   (clock),
      .wr_en   (sw_wr),
      .wr_addr (sel_ff),
      .wr_data (sw_wdata),
      .rd_en   (sw_rd),
      .rd_addr (sel_in),
      .rd_data (sw_q)
   );

   drr_ram #(.WIDTH(drr_pkg::PKT_W), .DEPTH(PD)) u_pkt_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_arrive),
      .wr_addr (pkt_waddr),
      .wr_data (pkt_wdata),
      .rd_en   (cmd.pkt_rd),
      .rd_addr (pkt_raddr),
      .rd_data (pkt_q)
   );

   always_comb begin
      link_busy_in = link_busy_ff;
      cur_in       = cur_ff;
      if (cmd.rsp_en) begin
         case (cmd.rsp_kind)
            drr_pkg::RSP_GRANT_REQ: link_busy_in = 1'b1;
            drr_pkg::RSP_IDLE:      link_busy_in = 1'b0;
            drr_pkg::RSP_GRANT_SEL: begin
               link_busy_in = 1'b1;
               cur_in       = sel_ff;
            end
            default: link_busy_in = link_busy_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff    <= drr_pkg::QUANTUM_RESET;
         link_busy_ff  <= 1'b0;
         cur_ff        <= '0;
         sel_ff        <= '0;
         valid_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         credit_any_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            quantum_ff <= csr_quantum;
         end
         link_busy_ff  <= link_busy_in;
         cur_ff        <= cur_in;
         sel_ff        <= sel_in;
         rsp_strobe_ff <= cmd.rsp_en;
         if (sw_rd) begin
            rd_valid_ff <= valid_ff[sel_in];
         end
         if (sw_wr) begin
            valid_ff[sel_ff] <= 1'b1;
         end
         if (cmd.clr_credit) begin
            credit_any_ff <= 1'b0;
         end else if (cmd.wr_visit && cnt != '0 && credit_ff != '0) begin
            credit_any_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_func_ff <= req_func;
         req_sess_ff <= req_session;
         req_len_ff  <= req_packet_length;
         req_wt_ff   <= req_weight;
      end
      if (cmd.mul) begin
         credit_ff <= drr_pkg::CREDIT_W'(quantum_ff) * drr_pkg::CREDIT_W'(pwt);
      end
      if (cmd.rsp_en) begin
         case (cmd.rsp_kind)
            drr_pkg::RSP_GRANT_REQ: begin
               rsp_status_ff <= drr_pkg::ST_GRANTED;
               rsp_sess_ff   <= req_sess_ff;
               rsp_len_ff    <= req_len_ff;
            end
            drr_pkg::RSP_QUEUED: begin
               rsp_status_ff <= drr_pkg::ST_QUEUED;
               rsp_sess_ff   <= req_sess_ff;
               rsp_len_ff    <= '0;
            end
            drr_pkg::RSP_DROP: begin
               rsp_status_ff <= drr_pkg::ST_DROPPED;
               rsp_sess_ff   <= req_sess_ff;
               rsp_len_ff    <= '0;
            end
            drr_pkg::RSP_GRANT_SEL: begin
               rsp_status_ff <= drr_pkg::ST_GRANTED;
               rsp_sess_ff   <= drr_pkg::SID_W'(sel_ff);
               rsp_len_ff    <= plen;
            end
            default: begin
               rsp_status_ff <= drr_pkg::ST_IDLE;
               rsp_sess_ff   <= '0;
               rsp_len_ff    <= '0;
            end
         endcase
      end
   end

   always_comb begin
      stat.func       = req_func_ff;
      stat.link_busy  = link_busy_ff;
      stat.sess_oor   = (32'(req_sess_ff) >= 32'(SESSIONS));
      stat.full       = (cnt == CW'(QUEUE_DEPTH));
      stat.cnt_zero   = (cnt == '0);
      stat.cur_fits   = (DW'(plen) <= def);
      stat.visit_fits = vfits;
      stat.at_cur     = (sel_ff == cur_ff);
      stat.credit_any = credit_any_ff | ((cnt != '0) && (credit_ff != '0));
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_grant_session = rsp_sess_ff;
   assign rsp_grant_length  = rsp_len_ff;

endmodule
`default_nettype wire

// ----- design/deficit_round_robin_scheduler.sv -----
// Top level of the weighted deficit round robin packet scheduler.
// A command is taken when start is high and busy is low; its single result
// appears for one cycle with rsp_strobe and cannot be stalled, so the receiver
// must take it when it comes. An arrival is answered from dispatch (idle link or
// dropped out-of-range session) or else after a session table read. A finished
// transmission reads the session table and packet store and ends there when the
// current session keeps the link; otherwise every session visit reads the session
// table and then the packet store, one after the other, and multiplies the credit;
// the scan runs round after round until the first head packet fits or the link
// goes idle, so the session needing the fewest rounds sets its length.
// Quantum may be written through the csr_ port only while the block is idle.
`default_nettype none
module deficit_round_robin_scheduler #(
   parameter int SESSIONS    = drr_pkg::SESSIONS_DEF,
   parameter int QUEUE_DEPTH = drr_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output      logic                        busy,
   input  wire logic                        req_func,
   input  wire logic [drr_pkg::SID_W-1:0]   req_session,
   input  wire logic [drr_pkg::LEN_W-1:0]   req_packet_length,
   input  wire logic [drr_pkg::WT_W-1:0]    req_weight,
   input  wire logic                        csr_valid,
   output      logic                        csr_ready,
   input  wire logic [drr_pkg::QUANT_W-1:0] csr_quantum,
   output      logic                        rsp_strobe,
   output      logic [1:0]                  rsp_status,
   output      logic [drr_pkg::SID_W-1:0]   rsp_grant_session,
   output      logic [drr_pkg::LEN_W-1:0]   rsp_grant_length
);

   drr_pkg::cmd_type  cmd;
   drr_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   drr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   drr_dp #(
      .SESSIONS    (SESSIONS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_func),
      .req_session       (req_session),
      .req_packet_length (req_packet_length),
      .req_weight        (req_weight),
      .csr_wr            (csr_valid & csr_ready),
      .csr_quantum       (csr_quantum),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_grant_session (rsp_grant_session),
      .rsp_grant_length  (rsp_grant_length)
   );

endmodule
`default_nettype wire
